>>> src/cdbp_pkg.sv
// shared types and constants for the core/delta block parser
package cdbp_pkg;

    localparam int unsigned CodeW   = 2;
    localparam int unsigned CountW  = 6;
    localparam int unsigned CoordW  = 14;
    localparam int unsigned ByteW   = 8;
    localparam int unsigned KindW   = 2;
    localparam int unsigned ApbAddrW = 3;
    localparam int unsigned ApbDataW = 32;

    localparam logic [CodeW-1:0] CoreAngularReset  = 2'd1;
    localparam logic [CodeW-1:0] DeltaAngularReset = 2'd1;

    localparam logic RegCoreAngular  = 1'b0;
    localparam logic RegDeltaAngular = 1'b1;

    localparam logic [KindW-1:0] KindCore  = 2'd0;
    localparam logic [KindW-1:0] KindDelta = 2'd1;
    localparam logic [KindW-1:0] KindEnd   = 2'd2;

    typedef enum logic [3:0] {
        PH_WAIT      = 4'd0,
        PH_CORE_XH   = 4'd1,
        PH_CORE_XL   = 4'd2,
        PH_CORE_YH   = 4'd3,
        PH_CORE_YL   = 4'd4,
        PH_CORE_ANG  = 4'd5,
        PH_DELTA_HDR = 4'd6,
        PH_DEL_XH    = 4'd7,
        PH_DEL_XL    = 4'd8,
        PH_DEL_YH    = 4'd9,
        PH_DEL_YL    = 4'd10,
        PH_DEL_A1    = 4'd11,
        PH_DEL_A2    = 4'd12,
        PH_DEL_A3    = 4'd13
    } t_phase;

    typedef struct packed {
        logic [ByteW-1:0] data_byte;
        logic             block_start;
    } t_in_beat;

    typedef struct packed {
        logic [KindW-1:0]  point_kind;
        logic [CoordW-1:0] coord_x;
        logic [CoordW-1:0] coord_y;
        logic              angle_present;
        logic [ByteW-1:0]  angle_first;
        logic [ByteW-1:0]  angle_second;
        logic [ByteW-1:0]  angle_third;
        logic              end_of_block;
    } t_out_beat;

    typedef struct packed {
        t_phase            phase;
        logic [CountW-1:0] points_left;
        logic              angular;
        logic [CoordW-1:0] x_accum;
        logic [CoordW-1:0] y_accum;
        logic [ByteW-1:0]  hold_a1;
        logic [ByteW-1:0]  hold_a2;
    } t_parse_state;

    typedef struct packed {
        logic [CodeW-1:0] core_code;
        logic [CodeW-1:0] delta_code;
    } t_cfg;

endpackage

>>> src/cdbp_step.sv
// next parse state and result for one byte of the block
module cdbp_step
    import cdbp_pkg::*;
(
    input  t_parse_state i_state,
    input  t_in_beat     i_beat,
    input  t_cfg         i_cfg,
    output t_parse_state o_state,
    output logic         o_res_valid,
    output t_out_beat    o_res
);

    logic [ByteW-1:0]  b;
    logic [CodeW-1:0]  hdr_type;
    logic [CountW-1:0] left_dec;
    logic [CoordW-1:0] y_low;
    logic              last_delta;

    assign b          = i_beat.data_byte;
    assign hdr_type   = b[7:6];
    assign left_dec   = i_state.points_left - CountW'(1);
    assign y_low      = i_state.y_accum | CoordW'(b);
    assign last_delta = (i_state.points_left <= CountW'(1));

    always_comb begin
        o_state     = i_state;
        o_res_valid = 1'b0;
        o_res       = '0;

        if (i_beat.block_start) begin
            o_state.angular     = (hdr_type == i_cfg.core_code);
            o_state.points_left = {2'b00, b[3:0]};
            o_state.phase       = (b[3:0] != 4'd0) ? PH_CORE_XH : PH_DELTA_HDR;
        end else begin
            unique case (i_state.phase)
                PH_CORE_XH, PH_DEL_XH: begin
                    o_state.x_accum = {b[5:0], 8'h00};
                    o_state.phase   = t_phase'(i_state.phase + 4'd1);
                end
                PH_CORE_XL, PH_DEL_XL: begin
                    o_state.x_accum = i_state.x_accum | CoordW'(b);
                    o_state.phase   = t_phase'(i_state.phase + 4'd1);
                end
                PH_CORE_YH, PH_DEL_YH: begin
                    o_state.y_accum = {b[5:0], 8'h00};
                    o_state.phase   = t_phase'(i_state.phase + 4'd1);
                end
                PH_CORE_YL, PH_CORE_ANG: begin
                    if (i_state.phase == PH_CORE_YL) begin
                        o_state.y_accum = y_low;
                    end
                    if (i_state.phase == PH_CORE_YL && i_state.angular) begin
                        o_state.phase = PH_CORE_ANG;
                    end else begin
                        o_res_valid            = 1'b1;
                        o_res.point_kind       = KindCore;
                        o_res.coord_x          = i_state.x_accum;
                        o_res.coord_y          = (i_state.phase == PH_CORE_YL) ?
                                                 y_low : i_state.y_accum;
                        o_res.angle_present    = i_state.angular;
                        o_res.angle_first      = (i_state.phase == PH_CORE_ANG &&
                                                  i_state.angular) ? b : '0;
                        o_state.points_left    = left_dec;
                        o_state.phase          = (left_dec != '0) ? PH_CORE_XH
                                                                  : PH_DELTA_HDR;
                    end
                end
                PH_DELTA_HDR: begin
                    o_state.angular     = (hdr_type == i_cfg.delta_code);
                    o_state.points_left = b[5:0];
                    if (b[5:0] == '0) begin
                        o_res_valid        = 1'b1;
                        o_res.point_kind   = KindEnd;
                        o_res.end_of_block = 1'b1;
                        o_state.phase      = PH_WAIT;
                    end else begin
                        o_state.phase = PH_DEL_XH;
                    end
                end
                PH_DEL_YL: begin
                    o_state.y_accum = y_low;
                    if (i_state.angular) begin
                        o_state.phase = PH_DEL_A1;
                    end else begin
                        o_state.hold_a1     = '0;
                        o_state.hold_a2     = '0;
                        o_res_valid         = 1'b1;
                        o_res.point_kind    = KindDelta;
                        o_res.coord_x       = i_state.x_accum;
                        o_res.coord_y       = y_low;
                        o_res.end_of_block  = last_delta;
                        o_state.points_left = left_dec;
                        o_state.phase       = last_delta ? PH_WAIT : PH_DEL_XH;
                    end
                end
                PH_DEL_A1: begin
                    o_state.hold_a1 = b;
                    o_state.phase   = PH_DEL_A2;
                end
                PH_DEL_A2: begin
                    o_state.hold_a2 = b;
                    o_state.phase   = PH_DEL_A3;
                end
                PH_DEL_A3: begin
                    o_res_valid         = 1'b1;
                    o_res.point_kind    = KindDelta;
                    o_res.coord_x       = i_state.x_accum;
                    o_res.coord_y       = i_state.y_accum;
                    o_res.angle_present = i_state.angular;
                    o_res.angle_first   = i_state.angular ? i_state.hold_a1 : '0;
                    o_res.angle_second  = i_state.angular ? i_state.hold_a2 : '0;
                    o_res.angle_third   = i_state.angular ? b : '0;
                    o_res.end_of_block  = last_delta;
                    o_state.points_left = left_dec;
                    o_state.phase       = last_delta ? PH_WAIT : PH_DEL_XH;
                end
                default: begin
                    o_state.phase = PH_WAIT;
                end
            endcase
        end
    end

endmodule

>>> src/core_delta_block_parser.sv
// core/delta block parser top level: input register, parse step, result register, apb regs
//
//  channel | direction | handshake                      | payload
//  in      | input     | i_in_valid / o_in_ready        | i_in_data  (t_in_beat)
//  out     | output    | o_out_valid / i_out_ready      | o_out_data (t_out_beat)
//  apb     | input     | psel, penable, pwrite, pready  | paddr, pwdata, prdata
//
// one byte per cycle sustained unless the result beat stalls on a byte that yields a point
// the parse step sits between the input register and the result register
// a byte that yields a point waits in the input register only while the result beat stalls
// bytes that yield no point never stall
// synchronous active-low reset clears the parse phase, counters and valid flags
module core_delta_block_parser
    import cdbp_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  t_in_beat            i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output t_out_beat           o_out_data,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [ApbAddrW-1:0] paddr,
    input  logic [ApbDataW-1:0] pwdata,
    output logic [ApbDataW-1:0] prdata,
    output logic                pready
);

    t_cfg         r_cfg;
    logic         r_in_valid;
    t_in_beat     r_in_data;
    t_parse_state r_state;
    t_parse_state n_state;
    logic         r_out_valid;
    t_out_beat    r_out_data;
    logic         step_res_valid;
    t_out_beat    step_res;
    logic         slot_free;
    logic         consume;

    cdbp_step u_step (
        .i_state     (r_state),
        .i_beat      (r_in_data),
        .i_cfg       (r_cfg),
        .o_state     (n_state),
        .o_res_valid (step_res_valid),
        .o_res       (step_res)
    );

    assign slot_free  = !r_out_valid || i_out_ready;
    assign consume    = r_in_valid && (!step_res_valid || slot_free);
    assign o_in_ready = !r_in_valid || consume;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    assign pready = 1'b1;
    always_comb begin
        prdata = '0;
        unique case (paddr[2])
            RegCoreAngular:  prdata = ApbDataW'(r_cfg.core_code);
            RegDeltaAngular: prdata = ApbDataW'(r_cfg.delta_code);
            default:         prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.core_code  <= CoreAngularReset;
            r_cfg.delta_code <= DeltaAngularReset;
        end else if (psel && penable && pwrite) begin
            unique case (paddr[2])
                RegCoreAngular:  r_cfg.core_code  <= pwdata[CodeW-1:0];
                RegDeltaAngular: r_cfg.delta_code <= pwdata[CodeW-1:0];
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_data <= i_in_data;
        end
    end

    // parse state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '{phase: PH_WAIT, default: '0};
        end else if (consume) begin
            r_state <= n_state;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (slot_free) begin
            r_out_valid <= consume && step_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (consume && step_res_valid) begin
            r_out_data <= step_res;
        end
    end

endmodule
